// ===== src/tvp_pkg.sv =====
package tvp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef logic [2:0] t_status;

    localparam t_status ST_PROFILED = 3'd0;
    localparam t_status ST_BAD_FRAC = 3'd1;
    localparam t_status ST_NO_RAMPS = 3'd2;
    localparam t_status ST_ZERO_MOVE = 3'd3;
    localparam t_status ST_PAST_END = 3'd4;
    localparam t_status ST_HOLDING = 3'd5;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ACCEL_FRAC = 3'd0;
    localparam t_cfg_idx CFG_DECEL_FRAC = 3'd1;
    localparam t_cfg_idx CFG_TOP_SPEED = 3'd2;
    localparam t_cfg_idx CFG_START_SPEED = 3'd3;
    localparam t_cfg_idx CFG_ARRIVE_BAND = 3'd4;

    localparam logic [16:0] RST_ACCEL_FRAC = 17'd16384;
    localparam logic [16:0] RST_DECEL_FRAC = 17'd16384;
    localparam logic [30:0] RST_TOP_SPEED = 31'd65536;
    localparam logic [30:0] RST_START_SPEED = 31'd0;
    localparam logic [30:0] RST_ARRIVE_BAND = 31'd6554;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // magnitude of a signed 33-bit difference
    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

// ===== src/trapezoid_velocity_planner.sv =====
// Trapezoidal velocity planner, Q16.16, one shared 66-bit add/subtract unit under a sequencer.
// The set-up item of a move squares the speeds, runs two 62-step divisions (each skipped for an
// empty segment) and checks for past end; a profiled item then, on a ramp, runs a 34-step
// multiply and a 32-step root (the root is skipped if its argument is not positive), while cruising
// skips both. One item at a time; o_s_tready is high only when idle with no result waiting.
// Reset (i_rst_n low, synchronous) restores register defaults, clears history and flags, drops results.
module trapezoid_velocity_planner #(
    parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // [31:0] start_position, [63:32] end_position,
                                     // [95:64] measured_position
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] speed_command
    output logic [3:0]  o_m_tuser,   // [0] arrived, [3:1] status
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_wdata
);

    localparam logic [31:0] FRAC_ONE = 32'd1 << FRAC_BITS;

    localparam logic [5:0] DIV_STEPS = 6'd62;
    localparam logic [5:0] MUL_STEPS = 6'd34;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_TOP2 = 4'd2;
    localparam logic [3:0] S_ST2 = 4'd3;
    localparam logic [3:0] S_AD = 4'd4;
    localparam logic [3:0] S_SD = 4'd5;
    localparam logic [3:0] S_CRU = 4'd6;
    localparam logic [3:0] S_DSET = 4'd7;
    localparam logic [3:0] S_DIV = 4'd8;
    localparam logic [3:0] S_DEND = 4'd9;
    localparam logic [3:0] S_PAST = 4'd10;
    localparam logic [3:0] S_STEP = 4'd11;
    localparam logic [3:0] S_MUL = 4'd12;
    localparam logic [3:0] S_ARG = 4'd13;
    localparam logic [3:0] S_SQRT = 4'd14;
    localparam logic [3:0] S_FIN = 4'd15;

    // configuration
    logic [16:0] r_af, r_df;
    logic [30:0] r_top, r_st, r_band;

    // move history and profile
    logic signed [31:0] r_prior_s, r_prior_e;
    logic               r_arrived, r_ready;
    logic [32:0]        r_ad, r_sd;
    logic signed [33:0] r_cruise;
    logic signed [63:0] r_arate, r_drate;

    // per transaction
    logic [3:0]         r_state;
    logic signed [31:0] r_ps, r_pe, r_pm;
    logic               r_neg;
    logic [32:0]        r_total, r_s;
    logic [61:0]        r_top2, r_st2;

    // shared unit operands
    logic [5:0]  r_cnt;
    logic [63:0] r_aux, r_ud, r_acc;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [33:0] r_mb;
    logic        r_sticky, r_mneg, r_dneg, r_div_sel, r_dec;

    // result
    logic        r_pend;
    logic [31:0] r_res_speed;
    logic        r_res_arr;
    tvp_pkg::t_status r_res_st;
    logic        r_mvalid;
    logic [31:0] r_mdata;
    logic [3:0]  r_muser;

    // ---- small multiplier: squares and fraction products ----
    logic [32:0] w_ma;
    logic [30:0] w_mbm;
    logic [63:0] w_prod;

    always_comb begin
        case (r_state)
            S_TOP2: begin
                w_ma = 33'(r_top);
                w_mbm = r_top;
            end
            S_ST2: begin
                w_ma = 33'(r_st);
                w_mbm = r_st;
            end
            S_AD: begin
                w_ma = r_total;
                w_mbm = 31'(r_af);
            end
            S_SD: begin
                w_ma = r_total;
                w_mbm = 31'(r_df);
            end
            default: begin
                w_ma = '0;
                w_mbm = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mbm);

    logic [63:0] w_frac_dist;
    assign w_frac_dist = w_prod >> FRAC_BITS;

    // ---- shared add/subtract unit ----
    logic [65:0] w_add_a, w_add_b, w_sum;
    logic        w_sub;

    always_comb begin
        case (r_state)
            S_MUL: begin
                // double the accumulator, add the multiplicand for a set multiplier bit
                w_add_a = {1'b0, r_acc, 1'b0};
                w_add_b = r_mb[33] ? {2'b00, r_ud} : '0;
                w_sub = 1'b0;
            end
            S_DIV: begin
                w_add_a = 66'({r_rem[34:0], r_aux[61]});
                w_add_b = {2'b00, r_ud};
                w_sub = 1'b1;
            end
            S_SQRT: begin
                w_add_a = 66'({r_rem[33:0], r_aux[63:62]});
                w_add_b = 66'({r_root, 2'b01});
                w_sub = 1'b1;
            end
            default: begin
                w_add_a = '0;
                w_add_b = '0;
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum = w_add_a + (w_sub ? ~w_add_b : w_add_b) + 66'(w_sub);

    // ---- decisions ----
    logic               w_changed, w_bad, w_past;
    logic signed [34:0] w_s35, w_adcr, w_d35;
    logic               w_in_accel, w_in_cruise;
    logic [63:0]        w_p;
    logic [65:0]        w_arg, w_add_pos;
    logic [32:0]        w_to_end;
    logic [30:0]        w_vmag;
    logic [31:0]        w_v;
    logic [61:0]        w_num_mag;

    assign w_changed = (i_s_tdata[63:32] != r_prior_e) || (i_s_tdata[31:0] != r_prior_s);
    assign w_bad = (32'(r_af) > FRAC_ONE) || (32'(r_df) > FRAC_ONE);
    assign w_past = ((r_pe > r_ps) && (r_pm > r_pe)) || ((r_pe < r_ps) && (r_pm < r_pe));

    assign w_s35 = $signed({2'b00, r_s});
    assign w_adcr = $signed({2'b00, r_ad}) + $signed({r_cruise[33], r_cruise});
    assign w_d35 = w_s35 - w_adcr;
    assign w_in_accel = r_s < r_ad;
    assign w_in_cruise = w_s35 < w_adcr;

    // saturated product magnitude, then the root argument
    assign w_p = r_sticky ? tvp_pkg::S64_MAX : r_acc;
    assign w_add_pos = 66'(r_st2) + 66'(w_p);

    always_comb begin
        if (r_dec) begin
            w_arg = 66'(r_top2) - 66'(w_p);
        end else if (r_mneg) begin
            w_arg = 66'(r_st2) - 66'(w_p);
        end else if (w_add_pos > 66'(tvp_pkg::S64_MAX)) begin
            w_arg = 66'(tvp_pkg::S64_MAX);
        end else begin
            w_arg = w_add_pos;
        end
    end

    assign w_num_mag = (r_top2 < r_st2) ? (r_st2 - r_top2) : (r_top2 - r_st2);

    assign w_to_end = tvp_pkg::mag33($signed({r_pm[31], r_pm}) - $signed({r_pe[31], r_pe}));
    assign w_vmag = (r_root > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_root[30:0];
    assign w_v = r_neg ? 32'(-{1'b0, w_vmag}) : {1'b0, w_vmag};

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_af <= tvp_pkg::RST_ACCEL_FRAC;
            r_df <= tvp_pkg::RST_DECEL_FRAC;
            r_top <= tvp_pkg::RST_TOP_SPEED;
            r_st <= tvp_pkg::RST_START_SPEED;
            r_band <= tvp_pkg::RST_ARRIVE_BAND;
            r_prior_s <= '0;
            r_prior_e <= '0;
            r_arrived <= 1'b0;
            r_ready <= 1'b0;
            r_state <= S_IDLE;
            r_pend <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    tvp_pkg::CFG_ACCEL_FRAC: r_af <= i_cfg_wdata[16:0];
                    tvp_pkg::CFG_DECEL_FRAC: r_df <= i_cfg_wdata[16:0];
                    tvp_pkg::CFG_TOP_SPEED: r_top <= i_cfg_wdata;
                    tvp_pkg::CFG_START_SPEED: r_st <= i_cfg_wdata;
                    tvp_pkg::CFG_ARRIVE_BAND: r_band <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // hand a finished result to the output register as soon as it is free
            if (r_pend && (!r_mvalid || i_m_tready)) begin
                r_mvalid <= 1'b1;
                r_mdata <= r_res_speed;
                r_muser <= {r_res_st, r_res_arr};
                r_pend <= 1'b0;
            end else if (r_mvalid && i_m_tready) begin
                r_mvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        r_ps <= i_s_tdata[31:0];
                        r_pe <= i_s_tdata[63:32];
                        r_pm <= i_s_tdata[95:64];
                        // a new move forgets arrival and set-up
                        if (w_changed) begin
                            r_arrived <= 1'b0;
                            r_ready <= 1'b0;
                            r_prior_s <= i_s_tdata[31:0];
                            r_prior_e <= i_s_tdata[63:32];
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_arrived) begin
                        r_res_speed <= '0;
                        r_res_arr <= 1'b1;
                        r_res_st <= tvp_pkg::ST_HOLDING;
                        r_pend <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_total <= tvp_pkg::mag33($signed({r_pe[31], r_pe})
                                                  - $signed({r_ps[31], r_ps}));
                        r_s <= tvp_pkg::mag33($signed({r_pm[31], r_pm})
                                              - $signed({r_ps[31], r_ps}));
                        r_neg <= r_pe < r_ps;
                        r_state <= S_TOP2;
                    end
                end
                S_TOP2: begin
                    r_top2 <= w_prod[61:0];
                    r_state <= S_ST2;
                end
                S_ST2: begin
                    r_st2 <= w_prod[61:0];
                    if (r_ready) begin
                        r_state <= S_STEP;
                    end else if (w_bad) begin
                        r_res_speed <= '0;
                        r_res_arr <= 1'b0;
                        r_res_st <= tvp_pkg::ST_BAD_FRAC;
                        r_pend <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_af == '0 && r_df == '0) begin
                        r_res_speed <= {1'b0, r_top};
                        r_res_arr <= 1'b0;
                        r_res_st <= tvp_pkg::ST_NO_RAMPS;
                        r_pend <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_ps == r_pe) begin
                        r_res_speed <= '0;
                        r_res_arr <= 1'b0;
                        r_res_st <= tvp_pkg::ST_ZERO_MOVE;
                        r_pend <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_AD;
                    end
                end
                S_AD: begin
                    r_ad <= w_frac_dist[32:0];
                    r_state <= S_SD;
                end
                S_SD: begin
                    r_sd <= w_frac_dist[32:0];
                    r_state <= S_CRU;
                end
                S_CRU: begin
                    r_cruise <= $signed({1'b0, r_total}) - $signed({1'b0, r_ad})
                                - $signed({1'b0, r_sd});
                    r_div_sel <= 1'b0;
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    // skip the division for an empty segment
                    r_rem <= '0;
                    r_cnt <= DIV_STEPS;
                    if (!r_div_sel) begin
                        if (r_ad != '0) begin
                            r_aux <= 64'(w_num_mag);
                            r_dneg <= r_top2 < r_st2;
                            r_ud <= 64'({r_ad, 1'b0});
                            r_state <= S_DIV;
                        end else begin
                            r_arate <= '0;
                            r_div_sel <= 1'b1;
                        end
                    end else begin
                        if (r_sd != '0) begin
                            r_aux <= 64'(r_top2);
                            r_dneg <= 1'b0;
                            r_ud <= 64'({r_sd, 1'b0});
                            r_state <= S_DIV;
                        end else begin
                            r_drate <= '0;
                            r_state <= S_PAST;
                        end
                    end
                end
                S_DIV: begin
                    if (!w_sum[65]) begin
                        r_rem <= w_sum[35:0];
                    end else begin
                        r_rem <= {r_rem[34:0], r_aux[61]};
                    end
                    r_aux <= {r_aux[62:0], !w_sum[65]};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    if (!r_div_sel) begin
                        r_arate <= r_dneg ? -$signed(64'(r_aux[61:0]))
                                          : $signed(64'(r_aux[61:0]));
                        r_div_sel <= 1'b1;
                        r_state <= S_DSET;
                    end else begin
                        r_drate <= $signed(64'(r_aux[61:0]));
                        r_state <= S_PAST;
                    end
                end
                S_PAST: begin
                    if (w_past) begin
                        r_res_speed <= '0;
                        r_res_arr <= 1'b0;
                        r_res_st <= tvp_pkg::ST_PAST_END;
                        r_pend <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ready <= 1'b1;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_acc <= '0;
                    r_sticky <= 1'b0;
                    r_cnt <= MUL_STEPS;
                    if (w_in_accel) begin
                        r_dec <= 1'b0;
                        r_mneg <= r_arate[63];
                        r_ud <= r_arate[63] ? 64'(-r_arate) : 64'(r_arate);
                        r_mb <= {r_s, 1'b0};
                        r_state <= S_MUL;
                    end else if (w_in_cruise) begin
                        r_root <= {1'b0, r_top};
                        r_state <= S_FIN;
                    end else begin
                        r_dec <= 1'b1;
                        r_mneg <= 1'b0;
                        r_ud <= 64'(r_drate);
                        r_mb <= {w_d35[32:0], 1'b0};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= w_sum[63:0];
                    if (w_sum[65:63] != 3'd0) begin
                        r_sticky <= 1'b1;
                    end
                    r_mb <= {r_mb[32:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_ARG;
                    end
                end
                S_ARG: begin
                    r_rem <= '0;
                    r_root <= '0;
                    r_cnt <= SQRT_STEPS;
                    r_aux <= w_arg[63:0];
                    // a root argument at or below zero gives zero speed
                    if (!w_arg[65] && w_arg != '0) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SQRT: begin
                    if (!w_sum[65]) begin
                        r_rem <= w_sum[35:0];
                    end else begin
                        r_rem <= {r_rem[33:0], r_aux[63:62]};
                    end
                    r_root <= {r_root[30:0], !w_sum[65]};
                    r_aux <= {r_aux[61:0], 2'b00};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_to_end < 33'(r_band)) begin
                        r_arrived <= 1'b1;
                        r_res_speed <= '0;
                        r_res_arr <= 1'b1;
                        r_res_st <= tvp_pkg::ST_HOLDING;
                    end else begin
                        r_res_speed <= w_v;
                        r_res_arr <= 1'b0;
                        r_res_st <= tvp_pkg::ST_PROFILED;
                    end
                    r_pend <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // take a new item only when no earlier result still waits behind the output register
    assign o_s_tready = (r_state == S_IDLE) && !r_pend;
    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata = r_mdata;
    assign o_m_tuser = r_muser;

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_PREP))
        else $error("accepted transaction did not start the sequencer");

    a_arrive_needs_profile : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_arrived |-> r_ready)
        else $error("arrival flagged without a set-up profile");

    a_iter_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_MUL || r_state == S_SQRT) |-> (r_cnt != 6'd0))
        else $error("iteration counter ran out inside a shared-unit loop");

    a_arrived_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0])
            |-> (o_m_tdata == 32'd0 && o_m_tuser[3:1] == tvp_pkg::ST_HOLDING))
        else $error("arrived result carries a non-zero speed or wrong status");

endmodule
